@@ hw/rtl/scr_pkg.sv @@
// ============================================================================
// scr_pkg
// Shared types, constants and palette lookup for the square-root colour ramp.
// ============================================================================
package scr_pkg;

    localparam int STOP_IDX_W = 4;
    localparam int SQRT_STEPS_PER_STAGE = 2;

    typedef enum logic [2:0] {
        STOP_BLUE,
        STOP_CYAN,
        STOP_GREEN,
        STOP_YELLOW,
        STOP_ORANGE,
        STOP_RED
    } stop_color_t;

    typedef struct packed {
        logic valid;
        logic black;
    } scr_tag_t;

    // stops past the sixth repeat red
    function automatic stop_color_t stop_color(input logic [STOP_IDX_W-1:0] idx);
        stop_color_t c;
        unique case (idx)
            4'd0:    c = STOP_BLUE;
            4'd1:    c = STOP_CYAN;
            4'd2:    c = STOP_GREEN;
            4'd3:    c = STOP_YELLOW;
            4'd4:    c = STOP_ORANGE;
            default: c = STOP_RED;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/scr_if.sv @@
// ============================================================================
// scr_if
// Valid/ready channels for intensity input and RGB output.
// ============================================================================
interface scr_level_if #(
    parameter int LEVEL_W = 17
);
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface scr_rgb_if #(
    parameter int CHANNEL_BITS = 8
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ hw/rtl/sqrt_scaled_color_ramp.sv @@
// ============================================================================
// sqrt_scaled_color_ramp
// Intensity to RGB colour ramp through a square-root scaled palette.
// ============================================================================
// Channels: intensity (sink) carries level, unsigned Q1.FRAC_BITS where
// 2^FRAC_BITS is 1.0; levels above 1.0 saturate. color (source) carries
// red, green and blue of CHANNEL_BITS each. A transfer happens on a rising
// edge with valid and ready both high.
// Level zero maps to black. Otherwise the root of the level, scaled by
// NUM_STOPS-1 segments, blends two adjacent stops of the palette
// blue, cyan, green, yellow, orange, red.
// Stages in order: one input register, the square-root pipeline at two root
// bits per stage, then segment select, multiply and round/output stages.
// Throughput: one transfer per cycle while color is not stalled.
// Every stage holds its own valid bit; a stage takes new data whenever it is
// empty or its successor moves, so bubbles close up and intensity.ready stays
// high while color is stalled until the pipeline is full. Nothing is dropped
// or repeated under back-pressure.
// Reset clears all valid bits, so intensity.ready is already high at release.
// ============================================================================
module sqrt_scaled_color_ramp
    import scr_pkg::*;
#(
    parameter int NUM_STOPS    = 6,
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    scr_level_if.sink intensity,
    scr_rgb_if.source color
);

    scr_tag_t           root_tag;
    logic [FRAC_BITS:0] root;
    logic               root_ready;

    scr_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .level_valid (intensity.valid),
        .level       (intensity.level),
        .level_ready (intensity.ready),
        .root_tag    (root_tag),
        .root        (root),
        .root_ready  (root_ready)
    );

    scr_blend #(
        .NUM_STOPS    (NUM_STOPS),
        .FRAC_BITS    (FRAC_BITS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .root_tag   (root_tag),
        .root       (root),
        .root_ready (root_ready),
        .rgb_valid  (color.valid),
        .red        (color.red),
        .green      (color.green),
        .blue       (color.blue),
        .rgb_ready  (color.ready)
    );

    // input only back-pressured when the output itself is stalled
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !intensity.ready |-> color.valid && !color.ready)
        else $error("input stalled without output back-pressure");

endmodule

@@ hw/rtl/scr_sqrt.sv @@
// ============================================================================
// scr_sqrt
// Pipelined digit-by-digit integer square root of the saturated level,
// two root bits per stage.
// ============================================================================
module scr_sqrt
    import scr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               level_valid,
    input  logic [FRAC_BITS:0] level,
    output logic               level_ready,
    output scr_tag_t           root_tag,
    output logic [FRAC_BITS:0] root,
    input  logic               root_ready
);

    localparam int ROOT_BITS = FRAC_BITS + 1;
    localparam int REM_W     = ROOT_BITS + 2;
    localparam int X_W       = 2 * ROOT_BITS;
    localparam int NSTAGES   = (ROOT_BITS + SQRT_STEPS_PER_STAGE - 1) / SQRT_STEPS_PER_STAGE;

    logic                 v_reg     [NSTAGES+1];
    logic                 black_reg [NSTAGES+1];
    logic [X_W-1:0]       x_reg     [NSTAGES+1];
    logic [REM_W-1:0]     rem_reg   [NSTAGES+1];
    logic [ROOT_BITS-1:0] root_reg  [NSTAGES+1];
    logic [NSTAGES+1:0]   adv;
    logic [ROOT_BITS-1:0] level_sat;

    assign adv[NSTAGES+1] = root_ready;
    assign level_ready    = adv[0];

    // saturate anything above 1.0
    assign level_sat = level[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}} : level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv[0])
        begin
            v_reg[0] <= level_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            black_reg[0] <= (level == '0);
            x_reg[0]     <= {1'b0, level_sat, {FRAC_BITS{1'b0}}};
            rem_reg[0]   <= '0;
            root_reg[0]  <= '0;
        end
    end

    for (genvar s = 0; s <= NSTAGES; s++)
    begin : g_adv
        assign adv[s] = !v_reg[s] || adv[s+1];
    end

    for (genvar s = 0; s < NSTAGES; s++)
    begin : g_stage
        logic [X_W-1:0]       x_c;
        logic [REM_W-1:0]     rem_c;
        logic [ROOT_BITS-1:0] root_c;

        always_comb
        begin
            logic [REM_W-1:0] cand;
            logic [REM_W-1:0] trial;
            cand   = '0;
            trial  = '0;
            x_c    = x_reg[s];
            rem_c  = rem_reg[s];
            root_c = root_reg[s];
            for (int k = 0; k < SQRT_STEPS_PER_STAGE; k++)
            begin
                if (s * SQRT_STEPS_PER_STAGE + k < ROOT_BITS)
                begin
                    cand  = {rem_c[REM_W-3:0], x_c[X_W-1 -: 2]};
                    trial = {root_c, 2'b01};
                    if (cand >= trial)
                    begin
                        rem_c  = cand - trial;
                        root_c = {root_c[ROOT_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_c  = cand;
                        root_c = {root_c[ROOT_BITS-2:0], 1'b0};
                    end
                    x_c = {x_c[X_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (adv[s+1])
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[s+1])
            begin
                black_reg[s+1] <= black_reg[s];
                x_reg[s+1]     <= x_c;
                rem_reg[s+1]   <= rem_c;
                root_reg[s+1]  <= root_c;
            end
        end
    end

    assign root_tag = '{valid: v_reg[NSTAGES], black: black_reg[NSTAGES]};
    assign root     = root_reg[NSTAGES];

    // all radicand digits consumed by the last stage
    a_radicand_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGES] |-> x_reg[NSTAGES] == '0)
        else $error("radicand not fully consumed");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGES] |-> rem_reg[NSTAGES] <= REM_W'({root_reg[NSTAGES], 1'b0}))
        else $error("square root remainder out of range");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[NSTAGES] |-> root_reg[NSTAGES] <= {1'b1, {FRAC_BITS{1'b0}}})
        else $error("square root above one");

endmodule

@@ hw/rtl/scr_blend.sv @@
// ============================================================================
// scr_blend
// Segment select, palette lookup and per-channel linear interpolation,
// three register stages.
// ============================================================================
module scr_blend
    import scr_pkg::*;
#(
    parameter int NUM_STOPS    = 6,
    parameter int FRAC_BITS    = 16,
    parameter int CHANNEL_BITS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  scr_tag_t                root_tag,
    input  logic [FRAC_BITS:0]      root,
    output logic                    root_ready,
    output logic                    rgb_valid,
    output logic [CHANNEL_BITS-1:0] red,
    output logic [CHANNEL_BITS-1:0] green,
    output logic [CHANNEL_BITS-1:0] blue,
    input  logic                    rgb_ready
);

    localparam int ROOT_BITS = FRAC_BITS + 1;
    localparam int NSEG      = NUM_STOPS - 1;
    localparam int SEG_W     = $clog2(NUM_STOPS);
    localparam int P_W       = ROOT_BITS + SEG_W;
    localparam int PROD_W    = ROOT_BITS + CHANNEL_BITS + 2;
    localparam int CH_MAX    = (1 << CHANNEL_BITS) - 1;
    localparam int CH_FIFTH  = (CH_MAX * 2 + 5) / 10;
    localparam int CH_HALF   = (CH_MAX + 1) / 2;
    localparam int ROUND     = 1 << (FRAC_BITS - 1);
    localparam int CH_R      = 0;
    localparam int CH_G      = 1;
    localparam int CH_B      = 2;

    typedef logic [2:0][CHANNEL_BITS-1:0] rgb_t;

    function automatic rgb_t stop_rgb(input stop_color_t c);
        rgb_t v;
        v = '0;
        unique case (c)
            STOP_BLUE:
            begin
                v[CH_G] = CHANNEL_BITS'(CH_FIFTH);
                v[CH_B] = CHANNEL_BITS'(CH_MAX);
            end
            STOP_CYAN:
            begin
                v[CH_G] = CHANNEL_BITS'(CH_MAX);
                v[CH_B] = CHANNEL_BITS'(CH_MAX);
            end
            STOP_GREEN:
            begin
                v[CH_G] = CHANNEL_BITS'(CH_MAX);
            end
            STOP_YELLOW:
            begin
                v[CH_R] = CHANNEL_BITS'(CH_MAX);
                v[CH_G] = CHANNEL_BITS'(CH_MAX);
            end
            STOP_ORANGE:
            begin
                v[CH_R] = CHANNEL_BITS'(CH_MAX);
                v[CH_G] = CHANNEL_BITS'(CH_HALF);
            end
            default:
            begin
                v[CH_R] = CHANNEL_BITS'(CH_MAX);
            end
        endcase
        return v;
    endfunction

    logic adv_a;
    logic adv_b;
    logic adv_c;

    // stage A: position, segment and fraction
    logic                 a_v_reg;
    logic                 a_black_reg;
    logic [SEG_W-1:0]     seg_a_reg;
    logic [ROOT_BITS-1:0] u_a_reg;
    logic [P_W-1:0]       pos;
    logic [P_W-FRAC_BITS-1:0] seg_raw;
    logic [SEG_W-1:0]     seg_next;
    logic [ROOT_BITS-1:0] u_next;

    // stage B: products
    logic                     b_v_reg;
    logic                     b_black_reg;
    rgb_t                     base_reg;
    logic signed [PROD_W-1:0] prod_reg [3];
    rgb_t                     lo_rgb;
    rgb_t                     hi_rgb;
    logic signed [PROD_W-1:0] prod_next [3];

    // stage C: output register
    logic c_v_reg;
    rgb_t out_reg;
    rgb_t out_next;

    assign adv_c      = !c_v_reg || rgb_ready;
    assign adv_b      = !b_v_reg || adv_c;
    assign adv_a      = !a_v_reg || adv_b;
    assign root_ready = adv_a;

    always_comb
    begin
        pos     = P_W'(root) * P_W'(NSEG);
        seg_raw = pos[P_W-1:FRAC_BITS];
        if (seg_raw >= (P_W-FRAC_BITS)'(NSEG))
        begin
            seg_next = SEG_W'(NSEG - 1);
            u_next   = {1'b1, {FRAC_BITS{1'b0}}};
        end
        else
        begin
            seg_next = seg_raw[SEG_W-1:0];
            u_next   = {1'b0, pos[FRAC_BITS-1:0]};
        end
    end

    always_comb
    begin
        lo_rgb = stop_rgb(stop_color(STOP_IDX_W'(seg_a_reg)));
        hi_rgb = stop_rgb(stop_color(STOP_IDX_W'(SEG_W'(seg_a_reg + 1'b1))));
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PROD_W'($signed({1'b0, u_a_reg}))
                         * PROD_W'($signed({1'b0, hi_rgb[i]}) - $signed({1'b0, lo_rgb[i]}));
        end
    end

    always_comb
    begin
        logic signed [PROD_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            sum         = prod_reg[i] + PROD_W'(ROUND);
            out_next[i] = base_reg[i] + CHANNEL_BITS'(sum >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_v_reg <= root_tag.valid;
            end
            if (adv_b)
            begin
                b_v_reg <= a_v_reg;
            end
            if (adv_c)
            begin
                c_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            a_black_reg <= root_tag.black;
            seg_a_reg   <= seg_next;
            u_a_reg     <= u_next;
        end
        if (adv_b)
        begin
            b_black_reg <= a_black_reg;
            base_reg    <= lo_rgb;
            prod_reg    <= prod_next;
        end
        if (adv_c)
        begin
            out_reg <= b_black_reg ? '0 : out_next;
        end
    end

    assign rgb_valid = c_v_reg;
    assign red       = out_reg[CH_R];
    assign green     = out_reg[CH_G];
    assign blue      = out_reg[CH_B];

    // full fraction only on the clamped last segment
    a_clamp_last_seg: assert property (@(posedge clk) disable iff (!rst_n)
        a_v_reg && u_a_reg[FRAC_BITS] |->
            u_a_reg[FRAC_BITS-1:0] == '0 && seg_a_reg == SEG_W'(NSEG - 1))
        else $error("fraction of one outside last segment");

endmodule
